@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the packet tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define PS2_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define PS2_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PS2_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

    // widths fixed by the packet format and the register map
    localparam int COORD_BITS_DEF = 16;
    localparam int BYTE_W         = 8;
    localparam int SIZE_W         = 14;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 14;
    localparam int DELTA_W        = 10;
    localparam int RAW_W          = 9;
    localparam int POS_W          = 16;
    localparam int BTN_W          = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 2'd2;

    // register reset values
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd480;

    // status byte bit positions
    localparam int SYNC_BIT   = 3;
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    // saturated deltas on overflow (y already in screen direction)
    localparam logic signed [DELTA_W-1:0] DX_OVF_NEG = -10'sd256;
    localparam logic signed [DELTA_W-1:0] DX_OVF_POS = 10'sd255;
    localparam logic signed [DELTA_W-1:0] DY_OVF_NEG = 10'sd256;
    localparam logic signed [DELTA_W-1:0] DY_OVF_POS = -10'sd255;

    // position within a packet
    typedef enum logic [2:0] {
        ST_STATUS = 3'b001,
        ST_XMOVE  = 3'b010,
        ST_YMOVE  = 3'b100
    } byte_state_t;

    // controls for one axis update
    typedef struct packed {
        logic              clamp_en;
        logic [SIZE_W-1:0] size;
    } move_ctrl_t;

endpackage

@@ hw/rtl/ps2mpt_byte_if.sv @@
interface ps2mpt_byte_if;
    import ps2mpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/ps2mpt_pos_if.sv @@
interface ps2mpt_pos_if;
    import ps2mpt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [BTN_W-1:0]        buttons;

    modport source (output valid, output pos_x, output pos_y, output buttons, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input buttons, output ready);
endinterface

@@ hw/rtl/ps2mpt_axis_move.sv @@
module ps2mpt_axis_move #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]           cur,
    input  logic signed [ps2mpt_pkg::DELTA_W-1:0]  delta,
    input  ps2mpt_pkg::move_ctrl_t                 ctrl,
    output logic signed [COORD_BITS-1:0]           nxt
);
    import ps2mpt_pkg::*;

    // two guard bits cover the delta range and the unsigned bound
    localparam int SW = COORD_BITS + 2;

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] res;

    // full-precision sum
    assign sum = SW'(cur) + SW'(delta);

    // upper bound, zero size clamps to zero
    assign hi = (ctrl.size == '0) ? '0 : $signed(SW'(ctrl.size) - SW'(1));

    // clamp to [0, hi] or pass through for wrap
    always_comb
    begin
        res = sum;
        if (ctrl.clamp_en)
        begin
            if (sum < 0)
                res = '0;
            if (res > hi)
                res = hi;
        end
    end

    assign nxt = COORD_BITS'(res);

endmodule

@@ hw/rtl/ps2_mouse_packet_tracker.sv @@
// PS/2 mouse packet tracker: takes one mouse byte per beat on rx and sustains one byte per
// clock cycle. A byte lands in an input register and is decoded on the next cycle; the third
// byte of a packet updates the cursor and loads the result register, from which a position
// beat is offered on pos. While a result waits, rx keeps accepting until the third
// byte of the next packet reaches the decode stage, which then stalls rx.
// A first byte with bit 3 clear is dropped to regain sync. Deltas move the cursor,
// which wraps or, with clamp_enable set, stays in [0, size-1]. Writing screen_width or
// screen_height recenters the cursor; write registers only while no byte is in flight.
`include "assert_macros.svh"

module ps2_mouse_packet_tracker #(
    parameter int COORD_BITS = ps2mpt_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ps2mpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ps2mpt_pkg::CFG_DATA_W-1:0] cfg_data,
    ps2mpt_byte_if.sink                       rx,
    ps2mpt_pos_if.source                      pos
);
    import ps2mpt_pkg::*;

    localparam int EXT_W = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;

    // configuration
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              clamp_reg;

    // packet state
    byte_state_t       state_reg;
    byte_state_t       state_next;
    logic [BYTE_W-1:0] status_reg;
    logic [BYTE_W-1:0] xmove_reg;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_y_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // result register
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    logic [BTN_W-1:0]        out_btn_reg;

    logic                         is_last;
    logic                         advance;
    logic                         emit;
    logic signed [RAW_W-1:0]      x_raw;
    logic signed [RAW_W-1:0]      y_raw;
    logic signed [DELTA_W-1:0]    dx;
    logic signed [DELTA_W-1:0]    dy;
    logic signed [COORD_BITS-1:0] new_x;
    logic signed [COORD_BITS-1:0] new_y;
    logic signed [EXT_W-1:0]      x_ext;
    logic signed [EXT_W-1:0]      y_ext;
    logic [SIZE_W-1:0]            size_w;
    logic [SIZE_W-1:0]            size_h;
    logic                         size_write;
    move_ctrl_t                   ctrl_x;
    move_ctrl_t                   ctrl_y;

    // handshake: the decode stage stalls only when a result cannot be stored
    assign is_last = (state_reg == ST_YMOVE);
    assign advance = in_valid_reg && (!is_last || !out_valid_reg || pos.ready);
    assign emit    = advance && is_last;
    assign rx.ready = !in_valid_reg || advance;

    // next packet position
    always_comb
    begin
        case (state_reg)
            ST_STATUS: state_next = in_byte_reg[SYNC_BIT] ? ST_XMOVE : ST_STATUS;
            ST_XMOVE:  state_next = ST_YMOVE;
            ST_YMOVE:  state_next = ST_STATUS;
            default:   state_next = ST_STATUS;
        endcase
    end

    // deltas, y negated to screen direction
    assign x_raw = $signed({status_reg[X_SIGN_BIT], xmove_reg});
    assign y_raw = $signed({status_reg[Y_SIGN_BIT], in_byte_reg});

    always_comb
    begin
        if (status_reg[X_OVF_BIT])
            dx = status_reg[X_SIGN_BIT] ? DX_OVF_NEG : DX_OVF_POS;
        else
            dx = DELTA_W'(x_raw);
        if (status_reg[Y_OVF_BIT])
            dy = status_reg[Y_SIGN_BIT] ? DY_OVF_NEG : DY_OVF_POS;
        else
            dy = -DELTA_W'(y_raw);
    end

    // per-axis add and clamp
    assign ctrl_x = '{clamp_en: clamp_reg, size: width_reg};
    assign ctrl_y = '{clamp_en: clamp_reg, size: height_reg};

    ps2mpt_axis_move #(.COORD_BITS(COORD_BITS)) u_move_x (
        .cur   (cur_x_reg),
        .delta (dx),
        .ctrl  (ctrl_x),
        .nxt   (new_x)
    );

    ps2mpt_axis_move #(.COORD_BITS(COORD_BITS)) u_move_y (
        .cur   (cur_y_reg),
        .delta (dy),
        .ctrl  (ctrl_y),
        .nxt   (new_y)
    );

    assign x_ext = EXT_W'(new_x);
    assign y_ext = EXT_W'(new_y);

    // sizes after this cycle's write, used for recentering
    assign size_write = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
    assign size_w = (cfg_we && (cfg_index == REG_WIDTH))  ? cfg_data[SIZE_W-1:0] : width_reg;
    assign size_h = (cfg_we && (cfg_index == REG_HEIGHT)) ? cfg_data[SIZE_W-1:0] : height_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            clamp_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                REG_CLAMP:  clamp_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
    end

    // packet state and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_STATUS;
            status_reg <= '0;
            xmove_reg  <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance && (state_reg == ST_STATUS) && in_byte_reg[SYNC_BIT])
                status_reg <= in_byte_reg;
            if (advance && (state_reg == ST_XMOVE))
                xmove_reg <= in_byte_reg;
            if (size_write)
            begin
                cur_x_reg <= COORD_BITS'(size_w >> 1);
                cur_y_reg <= COORD_BITS'(size_h >> 1);
            end
            else if (emit)
            begin
                cur_x_reg <= new_x;
                cur_y_reg <= new_y;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pos.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg   <= x_ext[POS_W-1:0];
            out_y_reg   <= y_ext[POS_W-1:0];
            out_btn_reg <= status_reg[BTN_W-1:0];
        end
    end

    assign pos.valid   = out_valid_reg;
    assign pos.pos_x   = out_x_reg;
    assign pos.pos_y   = out_y_reg;
    assign pos.buttons = out_btn_reg;

    // checks
    `PS2_ASSERT_IMPL(a_sync_kept, clk, rst_n, state_reg != ST_STATUS, status_reg[SYNC_BIT],
        "packet in progress without a sync bit in its status byte")
    `PS2_ASSERT_NEXT(a_state_hold, clk, rst_n, !advance, $stable(state_reg),
        "packet position moved without a decoded byte")
    `PS2_ASSERT_IMPL(a_empty_takes, clk, rst_n, !in_valid_reg, rx.ready,
        "empty input register refused a beat")
    `PS2_ASSERT_NEXT(a_result_src, clk, rst_n, !emit && !out_valid_reg, !out_valid_reg,
        "result appeared without a third packet byte")

endmodule
